FILE: rtl/dzq_pkg.sv
package dzq_pkg;

   localparam int ANGLE_BITS  = 21;
   localparam int RANDOM_BITS = 16;
   localparam int OUT_BITS    = ANGLE_BITS + 1;
   localparam int CELLS       = ANGLE_BITS;

   localparam int REQ_DATA_BITS = ((ANGLE_BITS + RANDOM_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

   localparam logic [ANGLE_BITS-1:0] SMALL_ANGLE_LIMIT = ANGLE_BITS'(66);
   localparam logic [ANGLE_BITS-1:0] QSTEP_RESET       = ANGLE_BITS'(1144);
   localparam logic [ANGLE_BITS-1:0] DZW_RESET         = '0;

   typedef enum logic [0:0] {
      CSR_QSTEP = 1'b0,
      CSR_DZW   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   neg;
      logic                   bypass;
      logic [ANGLE_BITS-1:0]  raw;
      logic [ANGLE_BITS-1:0]  mag;
      logic [ANGLE_BITS-1:0]  step;
      logic [RANDOM_BITS-1:0] rnd;
      logic [ANGLE_BITS-1:0]  dvd;
      logic [ANGLE_BITS-1:0]  rem;
   } dzq_beat_type;

endpackage

FILE: rtl/dzq_cell.sv
module dzq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dzq_pkg::dzq_beat_type in_beat,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dzq_pkg::dzq_beat_type out_beat
);
   import dzq_pkg::*;

   logic                  valid_ff;
   dzq_beat_type          beat_ff;
   logic [ANGLE_BITS:0]   trial;
   logic [ANGLE_BITS:0]   step_ext;
   logic [ANGLE_BITS:0]   diff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign trial    = {beat_ff.rem, beat_ff.dvd[ANGLE_BITS-1]};
   assign step_ext = {1'b0, beat_ff.step};
   assign diff     = trial - step_ext;

   always_comb begin
      out_beat     = beat_ff;
      out_beat.dvd = {beat_ff.dvd[ANGLE_BITS-2:0], 1'b0};
      if (trial >= step_ext) begin
         out_beat.rem = diff[ANGLE_BITS-1:0];
      end else begin
         out_beat.rem = trial[ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= in_beat;
      end
   end

endmodule

FILE: rtl/dzq_round.sv
module dzq_round (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  dzq_pkg::dzq_beat_type          in_beat,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [dzq_pkg::OUT_BITS-1:0]   out_angle
);
   import dzq_pkg::*;

   typedef struct packed {
      logic                              neg;
      logic                              bypass;
      logic [ANGLE_BITS-1:0]             raw;
      logic [ANGLE_BITS-1:0]             step;
      logic [ANGLE_BITS-1:0]             rem;
      logic [ANGLE_BITS-1:0]             base;
      logic [ANGLE_BITS+RANDOM_BITS-1:0] prod;
   } prod_type;

   logic                              v1_ff, v2_ff, v3_ff;
   logic                              rdy1, rdy2, rdy3;
   dzq_beat_type                      s1_ff;
   prod_type                          s2_ff, s2_in;
   logic [OUT_BITS-1:0]               angle_ff, angle_in;

   logic [ANGLE_BITS+RANDOM_BITS-1:0] rem_scaled;
   logic                              up;
   logic [OUT_BITS-1:0]               res, limit, res_sat;

   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v3_ff;
   assign out_angle = angle_ff;

   always_comb begin
      s2_in.neg    = s1_ff.neg;
      s2_in.bypass = s1_ff.bypass;
      s2_in.raw    = s1_ff.raw;
      s2_in.step   = s1_ff.step;
      s2_in.rem    = s1_ff.rem;
      s2_in.base   = s1_ff.mag - s1_ff.rem;
      s2_in.prod   = (ANGLE_BITS+RANDOM_BITS)'(s1_ff.step)
                   * (ANGLE_BITS+RANDOM_BITS)'(s1_ff.rnd);
   end

   assign rem_scaled = {s2_ff.rem, {RANDOM_BITS{1'b0}}};
   assign up         = s2_ff.prod < rem_scaled;
   assign res        = OUT_BITS'(s2_ff.base)
                     + (up ? OUT_BITS'(s2_ff.step) : '0);
   assign limit      = s2_ff.neg ? (OUT_BITS'(1) << ANGLE_BITS)
                                 : ((OUT_BITS'(1) << ANGLE_BITS) - OUT_BITS'(1));
   assign res_sat    = (res > limit) ? limit : res;

   always_comb begin
      if (s2_ff.bypass) begin
         angle_in = {s2_ff.raw[ANGLE_BITS-1], s2_ff.raw};
      end else if (s2_ff.neg) begin
         angle_in = ~res_sat + OUT_BITS'(1);
      end else begin
         angle_in = res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_ff <= in_beat;
      end
      if (rdy2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && v2_ff) begin
         angle_ff <= angle_in;
      end
   end

endmodule

FILE: rtl/deadzone_stochastic_quantizer.sv
// Dithered deadzone quantizer for a steering angle.
//
// req_ channel: one beat per angle, angle_in with a random fraction. rsp_
// channel: one beat per request in request order, the angle rounded up or down
// to a multiple of the active step (small angles and a zero step pass through).
// csr_ channel: register writes, csr_index 0 is quantization_step, 1 is
// deadzone_width; always ready, to be used only while no request is in flight.
//
// Path from req acceptance to rsp_tvalid: one register in each remainder
// cell, one cell per magnitude bit, then the capture, product and output
// registers of the rounding stage.
// Throughput: one beat per cycle while rsp_tready stays high, set by the cell
// row, where each cell resolves one remainder bit and passes the beat on.
//
// Reset clears every stage valid and loads the register defaults. When
// rsp_tready is low the result holds in the output register; earlier stages
// keep filling their empty slots and req_tready drops once the whole chain
// is full.
module deadzone_stochastic_quantizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // angle_in, random_fraction, zero pad
   input  logic [dzq_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // angle_out, zero pad
   output logic [dzq_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [dzq_pkg::ANGLE_BITS-1:0]      csr_data
);
   import dzq_pkg::*;

   logic [ANGLE_BITS-1:0]  qstep_ff, dzw_ff;
   logic [ANGLE_BITS-1:0]  raw;
   logic [RANDOM_BITS-1:0] rnd;
   logic                   neg;
   logic [ANGLE_BITS-1:0]  mag;
   logic [ANGLE_BITS-1:0]  step;
   dzq_beat_type           front_beat;

   logic                   cell_valid [CELLS+1];
   logic                   cell_ready [CELLS+1];
   dzq_beat_type           cell_beat  [CELLS+1];
   logic [OUT_BITS-1:0]    angle_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         qstep_ff <= QSTEP_RESET;
         dzw_ff   <= DZW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_QSTEP: qstep_ff <= csr_data;
            CSR_DZW:   dzw_ff   <= csr_data;
            default:   ;
         endcase
      end
   end

   assign raw  = req_tdata[ANGLE_BITS-1:0];
   assign rnd  = req_tdata[ANGLE_BITS+RANDOM_BITS-1:ANGLE_BITS];
   assign neg  = raw[ANGLE_BITS-1];
   assign mag  = neg ? (~raw + ANGLE_BITS'(1)) : raw;
   assign step = (mag < dzw_ff) ? dzw_ff : qstep_ff;

   always_comb begin
      front_beat.neg    = neg;
      front_beat.bypass = (mag < SMALL_ANGLE_LIMIT) || (step == '0);
      front_beat.raw    = raw;
      front_beat.mag    = mag;
      front_beat.step   = step;
      front_beat.rnd    = rnd;
      front_beat.dvd    = mag;
      front_beat.rem    = '0;
   end

   assign cell_valid[0] = req_tvalid;
   assign cell_beat[0]  = front_beat;
   assign req_tready    = cell_ready[0];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      dzq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_beat   (cell_beat[i]),
         .out_valid (cell_valid[i+1]),
         .out_ready (cell_ready[i+1]),
         .out_beat  (cell_beat[i+1])
      );
   end

   dzq_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cell_valid[CELLS]),
      .in_ready  (cell_ready[CELLS]),
      .in_beat   (cell_beat[CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_angle (angle_out)
   );

   assign rsp_tdata = RSP_DATA_BITS'(angle_out);

`ifndef SYNTHESIS
   a_first_cell_loaded: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> cell_valid[1])
      else $error("accepted beat did not reach the first cell");

   a_rem_below_step: assert property (@(posedge clock) disable iff (reset)
      cell_valid[CELLS] && !cell_beat[CELLS].bypass
         |-> cell_beat[CELLS].rem < cell_beat[CELLS].step)
      else $error("final remainder not below step");

   a_reset_empties: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && !cell_valid[1] && !cell_valid[CELLS])
      else $error("pipeline not empty after reset");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import dzq_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int LATENCY_SLACK = 40;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 70;

   localparam int DIRECTED_ANGLES [20] = '{
      0, 1, -1, 65, -65, 66, -66, 1143, 1144, 1145,
      -1145, 2288, 572, -572, 1048575, -1048576, -1048575, 100000, -100000, 12345
   };
   localparam int PHASE_QSTEP [PHASES] = '{1, 1048576, 0, 1144, 1000, 1, 37, 0};
   localparam int PHASE_DZW   [PHASES] = '{0, 0, 300, 1048576, 20000, 1048576, 3, 0};

   class angle_scoreboard;
      logic [ANGLE_BITS-1:0] qstep;
      logic [ANGLE_BITS-1:0] dzw;
      logic [OUT_BITS-1:0]   expected_angles [$];
      int                    errors;

      function new();
         qstep  = QSTEP_RESET;
         dzw    = DZW_RESET;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [ANGLE_BITS-1:0] value);
         if (idx == CSR_QSTEP) qstep = value;
         else                  dzw   = value;
      endfunction

      function logic [OUT_BITS-1:0] quantize(logic [ANGLE_BITS-1:0] raw,
                                             logic [RANDOM_BITS-1:0] frac);
         logic                  neg;
         logic [ANGLE_BITS-1:0] neg_raw;
         bit [63:0]             mag, step, rem, res, lim;
         neg     = raw[ANGLE_BITS-1];
         neg_raw = -raw;
         mag     = neg ? neg_raw : raw;
         step    = (mag < dzw) ? dzw : qstep;
         // small angles and a zero step pass straight through
         if (mag < SMALL_ANGLE_LIMIT || step == 0)
            return {raw[ANGLE_BITS-1], raw};
         rem = mag % step;
         res = mag - rem;
         if (step * frac < (rem << RANDOM_BITS))
            res += step;
         lim = neg ? (64'd1 << ANGLE_BITS) : ((64'd1 << ANGLE_BITS) - 1);
         if (res > lim)
            res = lim;
         if (neg)
            res = ~res + 1;
         return res[OUT_BITS-1:0];
      endfunction

      function void note_request(logic [ANGLE_BITS-1:0] raw, logic [RANDOM_BITS-1:0] frac);
         expected_angles.push_back(quantize(raw, frac));
      endfunction

      function void check_result(logic [OUT_BITS-1:0] got);
         logic [OUT_BITS-1:0] want;
         if (expected_angles.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got %0d", $time, $signed(got));
            return;
         end
         want = expected_angles.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: angle_out mismatch, expected %0d, got %0d",
                     $time, $signed(want), $signed(got));
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [0:0]               csr_index  = CSR_QSTEP;
   logic [ANGLE_BITS-1:0]    csr_data   = '0;

   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     cycles        = 0;
   angle_scoreboard sb            = new();

   deadzone_stochastic_quantizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[OUT_BITS-1:0]);
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_angle(input logic [ANGLE_BITS-1:0] angle,
                             input logic [RANDOM_BITS-1:0] frac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({frac, angle});
      do @(posedge clock); while (!req_tready);
      sb.note_request(angle, frac);
   endtask

   task automatic write_regs(input logic [ANGLE_BITS-1:0] qs, input logic [ANGLE_BITS-1:0] dz);
      csr_valid <= 1'b1;
      csr_index <= CSR_QSTEP;
      csr_data  <= qs;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_QSTEP, qs);
      csr_index <= CSR_DZW;
      csr_data  <= dz;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_DZW, dz);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_angles.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   function automatic logic [ANGLE_BITS-1:0] pick_angle(input logic [ANGLE_BITS-1:0] qs,
                                                        input logic [ANGLE_BITS-1:0] dz);
      int v;
      int sgn;
      sgn = $urandom_range(1) ? -1 : 1;
      case ($urandom_range(4))
         0: v = sgn * int'($urandom_range(80));
         1: v = sgn * (int'(dz) + int'($urandom_range(8)) - 4);
         2: v = sgn * (int'(qs) * int'($urandom_range(6)) + int'($urandom_range(6)) - 3);
         default: v = int'($urandom);
      endcase
      return v[ANGLE_BITS-1:0];
   endfunction

   function automatic logic [RANDOM_BITS-1:0] pick_fraction();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return RANDOM_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned           k;
      int unsigned           p;
      int unsigned           n;
      logic [ANGLE_BITS-1:0] qs;
      logic [ANGLE_BITS-1:0] dz;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults, edges of the small-angle band, step boundaries
      for (k = 0; k < $size(DIRECTED_ANGLES); k++)
         send_angle(ANGLE_BITS'(DIRECTED_ANGLES[k]),
                    (k % 3 == 0) ? 16'h0000 : (k % 3 == 1) ? 16'hFFFF : 16'h8000);
      drain();

      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 87; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 87; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         if (p == PHASES - 1) begin
            qs = ANGLE_BITS'($urandom_range(1 << 20, 1));
            dz = ANGLE_BITS'($urandom_range(1 << 20, 0));
         end else begin
            qs = ANGLE_BITS'(PHASE_QSTEP[p]);
            dz = ANGLE_BITS'(PHASE_DZW[p]);
         end
         write_regs(qs, dz);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_angle(pick_angle(qs, dz), pick_fraction());
         drain();
      end

      if (sb.errors == 0 && sb.expected_angles.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
